// ===== rtl/rhsb_pkg.sv =====
// rhsb_pkg: shared widths, stage types and the division step of the rgb to hsb pipeline
// no dependencies; used by rgb_to_hsb_converter_top
`default_nettype none

package rhsb_pkg;

  localparam int unsigned CH_W       = 8;   // color channel width
  localparam int unsigned FRAC_W     = 16;  // q0.16 output fractions
  localparam int unsigned HDIV_W     = 11;  // hue divisor 6*d, at most 1530
  localparam int unsigned HNUM_W     = 12;  // signed hue numerator before wrap
  localparam int unsigned PRE_STAGES = 3;   // max/min, numerator, divider setup
  localparam int unsigned DIV_STEPS  = FRAC_W;
  localparam int unsigned NSTAGE     = PRE_STAGES + DIV_STEPS + 1;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    sector_t         sector;
  } pre0_t;

  typedef struct packed {
    logic [CH_W-1:0]          mx;
    logic [CH_W-1:0]          d;
    logic signed [HNUM_W-1:0] n;
  } pre1_t;

  typedef struct packed {
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   rem_s;
    logic [FRAC_W-1:0] q_s;
    logic [HDIV_W-1:0] dh;
    logic [HDIV_W-1:0] rem_h;
    logic [FRAC_W-1:0] q_h;
    logic              grey;
    logic              sat_full;
  } div_t;

  // one restoring step for both dividers: one quotient bit each
  function automatic div_t div_step(div_t s);
    div_t            o;
    logic [CH_W:0]   r2_s;
    logic [HDIV_W:0] r2_h;
    logic            ge_s;
    logic            ge_h;
    o    = s;
    r2_s = {s.rem_s, 1'b0};
    r2_h = {s.rem_h, 1'b0};
    ge_s = (r2_s >= {1'b0, s.mx});
    ge_h = (r2_h >= {1'b0, s.dh});
    o.rem_s = ge_s ? CH_W'(r2_s - {1'b0, s.mx}) : CH_W'(r2_s);
    o.rem_h = ge_h ? HDIV_W'(r2_h - {1'b0, s.dh}) : HDIV_W'(r2_h);
    o.q_s   = {s.q_s[FRAC_W-2:0], ge_s};
    o.q_h   = {s.q_h[FRAC_W-2:0], ge_h};
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsb_converter_top.sv =====
// rgb_to_hsb_converter_top: pixel rgb to hue, saturation and brightness pipeline
// depends on rhsb_pkg for stage types, widths and the division step
//
// Takes one pixel per clock when the output side keeps up, and passes each
// result through its stages in order: one stage finds the largest and
// smallest channel, one forms the hue numerator, one wraps it and sets up the
// dividers, sixteen stages each give one quotient bit of the saturation and
// hue divisions, and a last register drives the outputs. Every stage holds its
// word while the next one is full and stalled, so empty stages still take new
// pixels while a result waits. Grey pixels give zero hue and saturation, and
// saturation reaches 65535 when the smallest channel is zero and the largest is not.
`default_nettype none

module rgb_to_hsb_converter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_hue_frac,
  output logic [15:0]      out_sat_frac,
  output logic [7:0]       out_bright_level
);

  localparam int unsigned NS = rhsb_pkg::NSTAGE;
  localparam int unsigned CW = rhsb_pkg::CH_W;
  localparam int unsigned FW = rhsb_pkg::FRAC_W;
  localparam int unsigned HW = rhsb_pkg::HDIV_W;
  localparam int unsigned NW = rhsb_pkg::HNUM_W;
  localparam int unsigned DS = rhsb_pkg::DIV_STEPS;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  rhsb_pkg::pre0_t p0_r, p0_nxt;
  rhsb_pkg::pre1_t p1_r, p1_nxt;
  rhsb_pkg::div_t  div_r [0:DS];
  rhsb_pkg::div_t  d0_nxt;

  logic [FW-1:0] hue_r, hue_nxt;
  logic [FW-1:0] sat_r, sat_nxt;
  logic [CW-1:0] bright_r;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // stage 0: largest and smallest channel, ties go red then green
  always_comb begin
    logic red_max;
    logic green_max;
    logic [CW-1:0] mn_rg;
    red_max   = (in_red >= in_green) && (in_red >= in_blue);
    green_max = !red_max && (in_green >= in_blue);
    mn_rg     = (in_red < in_green) ? in_red : in_green;
    p0_nxt.red   = in_red;
    p0_nxt.green = in_green;
    p0_nxt.blue  = in_blue;
    p0_nxt.mn    = (in_blue < mn_rg) ? in_blue : mn_rg;
    if (red_max) begin
      p0_nxt.mx     = in_red;
      p0_nxt.sector = rhsb_pkg::SEC_RED;
    end else if (green_max) begin
      p0_nxt.mx     = in_green;
      p0_nxt.sector = rhsb_pkg::SEC_GREEN;
    end else begin
      p0_nxt.mx     = in_blue;
      p0_nxt.sector = rhsb_pkg::SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_r <= p0_nxt;
    end
  end

  // stage 1: chroma and hue numerator in units of 1/(6*d) turn
  always_comb begin
    logic [CW-1:0]          d;
    logic signed [NW-1:0]   base;
    logic signed [NW-1:0]   diff;
    d = p0_r.mx - p0_r.mn;
    case (p0_r.sector)
      rhsb_pkg::SEC_RED: begin
        base = '0;
        diff = $signed({{(NW-CW){1'b0}}, p0_r.green}) - $signed({{(NW-CW){1'b0}}, p0_r.blue});
      end
      rhsb_pkg::SEC_GREEN: begin
        base = $signed({{(NW-CW-1){1'b0}}, d, 1'b0});
        diff = $signed({{(NW-CW){1'b0}}, p0_r.blue}) - $signed({{(NW-CW){1'b0}}, p0_r.red});
      end
      rhsb_pkg::SEC_BLUE: begin
        base = $signed({{(NW-CW-2){1'b0}}, d, 2'b00});
        diff = $signed({{(NW-CW){1'b0}}, p0_r.red}) - $signed({{(NW-CW){1'b0}}, p0_r.green});
      end
      default: begin
        base = '0;
        diff = '0;
      end
    endcase
    p1_nxt.mx = p0_r.mx;
    p1_nxt.d  = d;
    p1_nxt.n  = base + diff;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_r <= p1_nxt;
    end
  end

  function automatic logic [HW-3:0] d_ext(logic [CW-1:0] d);
    return (HW-2)'(d);
  endfunction

  // stage 2: wrap negative hue and load both dividers
  always_comb begin
    logic [HW-1:0]        dh;
    logic signed [NW-1:0] nw;
    dh = HW'({d_ext(p1_r.d), 2'b00}) + HW'({d_ext(p1_r.d), 1'b0});
    nw = p1_r.n[NW-1] ? (p1_r.n + $signed({1'b0, dh})) : p1_r.n;
    d0_nxt.mx       = p1_r.mx;
    d0_nxt.rem_s    = p1_r.d;
    d0_nxt.q_s      = '0;
    d0_nxt.dh       = dh;
    d0_nxt.rem_h    = nw[HW-1:0];
    d0_nxt.q_h      = '0;
    d0_nxt.grey     = (p1_r.d == '0);
    d0_nxt.sat_full = (p1_r.d == p1_r.mx) && (p1_r.d != '0);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      div_r[0] <= d0_nxt;
    end
  end

  // stages 3 to 18: one quotient bit per stage
  for (genvar k = 1; k <= DS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        div_r[k] <= rhsb_pkg::div_step(div_r[k-1]);
      end
    end
  end

  // output stage: grey and full-saturation fixups
  always_comb begin
    hue_nxt = div_r[DS].grey ? '0 : div_r[DS].q_h;
    if (div_r[DS].grey) begin
      sat_nxt = '0;
    end else if (div_r[DS].sat_full) begin
      sat_nxt = '1;
    end else begin
      sat_nxt = div_r[DS].q_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= div_r[DS].mx;
    end
  end

  assign out_valid        = v_r[NS-1];
  assign out_hue_frac     = hue_r;
  assign out_sat_frac     = sat_r;
  assign out_bright_level = bright_r;

endmodule

`default_nettype wire
